### rtl/core/two_button_stopwatch_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Stopwatch controller assertion macros
// Clocked, reset-gated concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef TWO_BUTTON_STOPWATCH_CONTROLLER_UNIT_ASSERT_SVH
`define TWO_BUTTON_STOPWATCH_CONTROLLER_UNIT_ASSERT_SVH

// assertion sampled on the rising edge, switched off while reset is low
`define TBSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form of the above
`define TBSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `TBSC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

### rtl/core/tbsc_pkg.sv
// ----------------------------------------------------------------------------
// tbsc_pkg
// Shared types, mode codes, register indexes and CRC helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tbsc_pkg;

  localparam int unsigned ModeW = 3;

  localparam logic [ModeW-1:0] MODE_IDLE    = 3'd0;
  localparam logic [ModeW-1:0] MODE_CLEAR   = 3'd1;
  localparam logic [ModeW-1:0] MODE_RELEASE = 3'd2;
  localparam logic [ModeW-1:0] MODE_COUNT   = 3'd3;
  localparam logic [ModeW-1:0] MODE_SHOW    = 3'd4;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLEAR_HOLD = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SHOW       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BLINK      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_MAX  = 3'd4;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] CLEAR_HOLD_RST = 16'd3000;
  localparam logic [15:0] SHOW_RST       = 16'd5000;
  localparam logic [15:0] BLINK_RST      = 16'd250;
  localparam logic [16:0] COUNT_MAX_RST  = 17'd99999;

  localparam logic [31:0] NO_RECORD   = 32'hFFFF_FFFF;
  localparam logic [15:0] TIMER_MAX   = 16'hFFFF;
  localparam logic [16:0] SHOW_LIMIT  = 17'd99999;
  localparam logic [16:0] SMALL_LIMIT = 17'd9999;
  // ceil(2^19 / 10): x / 10 == (x * RECIP10) >> 19 for any 17-bit x
  localparam logic [15:0] RECIP10     = 16'd52429;

  localparam logic [31:0] NIB_TAB [16] = '{
    32'h0000_0000, 32'h1db7_1064, 32'h3b6e_20c8, 32'h26d9_30ac,
    32'h76dc_4190, 32'h6b6b_51f4, 32'h4db2_6158, 32'h5005_713c,
    32'hedb8_8320, 32'hf00f_9344, 32'hd6d6_a3e8, 32'hcb61_b38c,
    32'h9b64_c2b0, 32'h86d3_d2d4, 32'ha00a_e278, 32'hbdbd_f21c
  };

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] clear_hold_ms;
    logic [15:0] show_ms;
    logic [15:0] blink_ms;
    logic [16:0] count_max;
  } cfg_t;

  // controller state after one item, plus the storage strobe
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [16:0]      count;
    logic [31:0]      record;
    logic [16:0]      shown;
    logic             dashes;
    logic             blank;
    logic             rec_flag;
    logic             write;
  } step_t;

  function automatic logic [15:0] tick(input logic [15:0] t);
    tick = (t != TIMER_MAX) ? t + 16'd1 : t;
  endfunction

  // nibble-table CRC-32, bytes LSB first, whole CRC inverted after each byte
  function automatic logic [31:0] record_crc(input logic [31:0] v);
    logic [31:0] c;
    logic [7:0]  b;
    c = 32'hFFFF_FFFF;
    for (int i = 0; i < 4; i++) begin
      b = v[8*i +: 8];
      c = NIB_TAB[c[3:0] ^ b[3:0]] ^ (c >> 4);
      c = NIB_TAB[c[3:0] ^ b[7:4]] ^ (c >> 4);
      c = ~c;
    end
    record_crc = c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tbsc_ctrl.sv
// ----------------------------------------------------------------------------
// tbsc_ctrl
// Stopwatch state machine: one millisecond item per accepted input.
// ----------------------------------------------------------------------------
`default_nettype none

module tbsc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tbsc_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          left_i,
  input  wire logic          right_i,
  input  wire logic          clr_i,
  output logic               step_valid_o,
  input  wire logic          step_ready_i,
  output tbsc_pkg::step_t    step_o
);

  logic [tbsc_pkg::ModeW-1:0] mode_q, mode_d;
  logic [16:0] count_q, count_d;
  logic [31:0] record_q, record_d;
  logic [15:0] phase_q, phase_d;
  logic [15:0] blink_q, blink_d;
  logic [16:0] shown_q, shown_d;
  logic        dashes_q, dashes_d;
  logic        blank_q, blank_d;
  logic        rec_flag_q, rec_flag_d;
  logic        write_q, write_d;
  logic        valid_q;
  logic        accept;
  logic        both;

  assign in_ready_o = !valid_q || step_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign both       = left_i && right_i;

  always_comb begin
    mode_d     = mode_q;
    count_d    = count_q;
    record_d   = record_q;
    phase_d    = phase_q;
    blink_d    = blink_q;
    shown_d    = shown_q;
    dashes_d   = dashes_q;
    blank_d    = blank_q;
    rec_flag_d = rec_flag_q;
    write_d    = 1'b0;
    case (mode_q)
      tbsc_pkg::MODE_CLEAR: begin
        if (clr_i) begin
          phase_d = tbsc_pkg::tick(phase_q);
          if (phase_d >= cfg_i.clear_hold_ms) begin
            record_d = tbsc_pkg::NO_RECORD;
            write_d  = 1'b1;
            dashes_d = 1'b1;
          end
        end else begin
          mode_d  = tbsc_pkg::MODE_IDLE;
          phase_d = '0;
        end
      end
      tbsc_pkg::MODE_RELEASE: begin
        if (!left_i && !right_i) begin
          mode_d  = tbsc_pkg::MODE_COUNT;
          phase_d = '0;
        end
      end
      tbsc_pkg::MODE_COUNT: begin
        count_d  = (count_q < cfg_i.count_max) ? count_q + 17'd1 : '0;
        shown_d  = count_d;
        dashes_d = 1'b0;
        if (both) begin
          mode_d  = tbsc_pkg::MODE_SHOW;
          phase_d = '0;
          blink_d = '0;
        end
      end
      tbsc_pkg::MODE_SHOW: begin
        if ({15'd0, count_q} < record_q) begin
          record_d   = {15'd0, count_q};
          write_d    = 1'b1;
          rec_flag_d = 1'b1;
        end
        phase_d = tbsc_pkg::tick(phase_q);
        blink_d = tbsc_pkg::tick(blink_q);
        if (phase_d >= cfg_i.show_ms) begin
          mode_d     = tbsc_pkg::MODE_IDLE;
          dashes_d   = 1'b1;
          phase_d    = '0;
          rec_flag_d = 1'b0;
          blank_d    = 1'b0;
        end else if (rec_flag_d && blink_d >= cfg_i.blink_ms) begin
          blink_d = '0;
          // coming out of a blank half: show the result again
          if (blank_q) begin
            shown_d  = count_q;
            dashes_d = 1'b0;
          end
          blank_d = !blank_q;
        end
      end
      default: begin
        // idle, and any unused code behaves as idle
        mode_d = tbsc_pkg::MODE_IDLE;
        if (both) begin
          if (phase_q >= cfg_i.debounce_ms) begin
            count_d  = '0;
            shown_d  = '0;
            dashes_d = 1'b0;
            mode_d   = tbsc_pkg::MODE_RELEASE;
            phase_d  = '0;
          end else begin
            phase_d = tbsc_pkg::tick(phase_q);
          end
        end else begin
          phase_d = '0;
          if (clr_i) begin
            mode_d = tbsc_pkg::MODE_CLEAR;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= tbsc_pkg::MODE_IDLE;
      count_q    <= '0;
      record_q   <= tbsc_pkg::NO_RECORD;
      phase_q    <= '0;
      blink_q    <= '0;
      shown_q    <= '0;
      dashes_q   <= 1'b1;
      blank_q    <= 1'b0;
      rec_flag_q <= 1'b0;
      write_q    <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        mode_q     <= mode_d;
        count_q    <= count_d;
        record_q   <= record_d;
        phase_q    <= phase_d;
        blink_q    <= blink_d;
        shown_q    <= shown_d;
        dashes_q   <= dashes_d;
        blank_q    <= blank_d;
        rec_flag_q <= rec_flag_d;
        write_q    <= write_d;
        valid_q    <= 1'b1;
      end else if (step_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign step_valid_o    = valid_q;
  assign step_o.mode     = mode_q;
  assign step_o.count    = count_q;
  assign step_o.record   = record_q;
  assign step_o.shown    = shown_q;
  assign step_o.dashes   = dashes_q;
  assign step_o.blank    = blank_q;
  assign step_o.rec_flag = rec_flag_q;
  assign step_o.write    = write_q;

endmodule

`default_nettype wire

### rtl/core/tbsc_fmt.sv
// ----------------------------------------------------------------------------
// tbsc_fmt
// Display formatting and record CRC into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbsc_fmt (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_valid_i,
  output logic                step_ready_o,
  input  wire tbsc_pkg::step_t step_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [2:0]          mode_o,
  output logic [13:0]         display_value_o,
  output logic [1:0]          point_position_o,
  output logic                show_dashes_o,
  output logic                display_blank_o,
  output logic [16:0]         elapsed_count_o,
  output logic [31:0]         best_record_o,
  output logic                new_record_o,
  output logic                record_write_o,
  output logic [31:0]         record_crc_o
);

  logic        valid_q;
  logic        load;
  logic        dash;
  logic [32:0] prod;
  logic [13:0] dval;
  logic [1:0]  ppos;

  logic [2:0]  mode_q;
  logic [13:0] dval_q;
  logic [1:0]  ppos_q;
  logic        dash_q;
  logic        blank_q;
  logic [16:0] count_q;
  logic [31:0] record_q;
  logic        rec_flag_q;
  logic        write_q;
  logic [31:0] crc_q;

  assign step_ready_o = !valid_q || out_ready_i;
  assign load         = step_valid_i && step_ready_o;

  assign dash = step_i.dashes || (step_i.shown > tbsc_pkg::SHOW_LIMIT);
  assign prod = {16'd0, step_i.shown} * {17'd0, tbsc_pkg::RECIP10};

  always_comb begin
    if (dash) begin
      dval = '0;
      ppos = 2'd3;
    end else if (step_i.shown <= tbsc_pkg::SMALL_LIMIT) begin
      dval = step_i.shown[13:0];
      ppos = 2'd3;
    end else begin
      dval = prod[32:19];
      ppos = 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q     <= step_i.mode;
      dval_q     <= dval;
      ppos_q     <= ppos;
      dash_q     <= dash;
      blank_q    <= step_i.blank;
      count_q    <= step_i.count;
      record_q   <= step_i.record;
      rec_flag_q <= step_i.rec_flag;
      write_q    <= step_i.write;
      crc_q      <= tbsc_pkg::record_crc(step_i.record);
    end
  end

  assign out_valid_o      = valid_q;
  assign mode_o           = mode_q;
  assign display_value_o  = dval_q;
  assign point_position_o = ppos_q;
  assign show_dashes_o    = dash_q;
  assign display_blank_o  = blank_q;
  assign elapsed_count_o  = count_q;
  assign best_record_o    = record_q;
  assign new_record_o     = rec_flag_q;
  assign record_write_o   = write_q;
  assign record_crc_o     = crc_q;

endmodule

`default_nettype wire

### rtl/core/two_button_stopwatch_controller_unit.sv
// ----------------------------------------------------------------------------
// two_button_stopwatch_controller_unit
// Two-button stopwatch with best-time record and record CRC.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item is one millisecond sample of the three button levels.
//   Every accepted item yields exactly one result item on the output channel
//   (valid/ready) carrying mode, display fields, count, record and its CRC.
//   Registers are written over the cfg channel (index, data), always ready;
//   write them only while no item is in flight.
//   Path: an accepted input goes into the state register, then into the output
//   register that holds the formatted display and CRC.
//   Throughput: one item per clock while out_ready_i is high; next state is combinational.
//   Reset: idle mode, count 0, no record (all ones), dashes shown, register
//   defaults 50 / 3000 / 5000 / 250 / 99999.
//   Stall: when out_ready_i is low the result holds; at most one more item is taken
//   into the state stage, after which in_ready_o drops until the output moves.
// ----------------------------------------------------------------------------
`default_nettype none

module two_button_stopwatch_controller_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        left_start_pressed_i,
  input  wire logic        right_start_pressed_i,
  input  wire logic        clear_pressed_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       mode_o,
  output logic [13:0]      display_value_o,
  output logic [1:0]       point_position_o,
  output logic             show_dashes_o,
  output logic             display_blank_o,
  output logic [16:0]      elapsed_count_o,
  output logic [31:0]      best_record_o,
  output logic             new_record_o,
  output logic             record_write_o,
  output logic [31:0]      record_crc_o
);

  tbsc_pkg::cfg_t  cfg_q;
  tbsc_pkg::step_t step;
  logic            step_valid;
  logic            step_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= tbsc_pkg::DEBOUNCE_RST;
      cfg_q.clear_hold_ms <= tbsc_pkg::CLEAR_HOLD_RST;
      cfg_q.show_ms       <= tbsc_pkg::SHOW_RST;
      cfg_q.blink_ms      <= tbsc_pkg::BLINK_RST;
      cfg_q.count_max     <= tbsc_pkg::COUNT_MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tbsc_pkg::CFG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data_i[15:0];
        tbsc_pkg::CFG_CLEAR_HOLD: cfg_q.clear_hold_ms <= cfg_data_i[15:0];
        tbsc_pkg::CFG_SHOW:       cfg_q.show_ms       <= cfg_data_i[15:0];
        tbsc_pkg::CFG_BLINK:      cfg_q.blink_ms      <= cfg_data_i[15:0];
        tbsc_pkg::CFG_COUNT_MAX:  cfg_q.count_max     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tbsc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .left_i       (left_start_pressed_i),
    .right_i      (right_start_pressed_i),
    .clr_i        (clear_pressed_i),
    .step_valid_o (step_valid),
    .step_ready_i (step_ready),
    .step_o       (step)
  );

  tbsc_fmt u_fmt (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_valid_i     (step_valid),
    .step_ready_o     (step_ready),
    .step_i           (step),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mode_o           (mode_o),
    .display_value_o  (display_value_o),
    .point_position_o (point_position_o),
    .show_dashes_o    (show_dashes_o),
    .display_blank_o  (display_blank_o),
    .elapsed_count_o  (elapsed_count_o),
    .best_record_o    (best_record_o),
    .new_record_o     (new_record_o),
    .record_write_o   (record_write_o),
    .record_crc_o     (record_crc_o)
  );

`include "two_button_stopwatch_controller_unit_assert.svh"

  // no storage strobe while armed or counting; a show item may already be back in idle
  `TBSC_ASSERT_IMP(a_write_mode, clk_i, rst_ni, out_valid_o && record_write_o, (mode_o != tbsc_pkg::MODE_RELEASE) && (mode_o != tbsc_pkg::MODE_COUNT), "record write while armed or counting")
  // new-record flag lives only in the show phase
  `TBSC_ASSERT_IMP(a_newrec_mode, clk_i, rst_ni, out_valid_o && new_record_o, mode_o == tbsc_pkg::MODE_SHOW, "new record flag outside show")
  // blinking only happens for a new record
  `TBSC_ASSERT_IMP(a_blank_rec, clk_i, rst_ni, out_valid_o && display_blank_o, new_record_o, "blank without new record")
  // a shown result stays in place while the state stage is stalled
  `TBSC_ASSERT(a_step_hold, clk_i, rst_ni, step_valid && !step_ready |=> $stable(step), "state stage changed while stalled")

endmodule

`default_nettype wire

### bench/two_button_stopwatch_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// Stopwatch controller testbench
// Sends millisecond button samples and register writes over the valid/ready
// channels. A tracker class predicts every result item from its own copy of
// the controller state and checks each one field by field. The idle pattern
// on both channels changes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

typedef struct packed {
  logic [2:0]  mode;
  logic [13:0] display_value;
  logic [1:0]  point_position;
  logic        show_dashes;
  logic        display_blank;
  logic [16:0] elapsed_count;
  logic [31:0] best_record;
  logic        new_record;
  logic        record_write;
  logic [31:0] record_crc;
} display_item_t;

class stopwatch_tracker;
  tbsc_pkg::cfg_t cfg;
  logic [2:0]    mode_q;
  logic [16:0]   count_q;
  logic [31:0]   best_q;
  logic [15:0]   phase_q;
  logic [15:0]   blink_q;
  logic [16:0]   shown_q;
  logic          dashes_q;
  logic          blank_q;
  logic          rec_flag_q;
  display_item_t expected_displays[$];
  int unsigned   mismatches;
  int unsigned   results_seen;

  function new();
    cfg.debounce_ms   = tbsc_pkg::DEBOUNCE_RST;
    cfg.clear_hold_ms = tbsc_pkg::CLEAR_HOLD_RST;
    cfg.show_ms       = tbsc_pkg::SHOW_RST;
    cfg.blink_ms      = tbsc_pkg::BLINK_RST;
    cfg.count_max     = tbsc_pkg::COUNT_MAX_RST;
    mode_q       = tbsc_pkg::MODE_IDLE;
    count_q      = '0;
    best_q       = tbsc_pkg::NO_RECORD;
    phase_q      = '0;
    blink_q      = '0;
    shown_q      = '0;
    dashes_q     = 1'b1;
    blank_q      = 1'b0;
    rec_flag_q   = 1'b0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function void write_register(logic [2:0] idx, logic [16:0] data);
    case (idx)
      tbsc_pkg::CFG_DEBOUNCE:   cfg.debounce_ms   = data[15:0];
      tbsc_pkg::CFG_CLEAR_HOLD: cfg.clear_hold_ms = data[15:0];
      tbsc_pkg::CFG_SHOW:       cfg.show_ms       = data[15:0];
      tbsc_pkg::CFG_BLINK:      cfg.blink_ms      = data[15:0];
      tbsc_pkg::CFG_COUNT_MAX:  cfg.count_max     = data;
      default: ;
    endcase
  endfunction

  function logic [15:0] sat_inc(logic [15:0] t);
    return (t == tbsc_pkg::TIMER_MAX) ? t : t + 16'd1;
  endfunction

  // bit-serial reflected CRC, bytes LSB first, inverted after each byte
  function logic [31:0] crc_of_best(logic [31:0] v);
    logic [31:0] c;
    c = '1;
    for (int i = 0; i < 32; i++) begin
      c = (c[0] ^ v[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      if (i % 8 == 7) c = ~c;
    end
    return c;
  endfunction

  function int pending();
    return expected_displays.size();
  endfunction

  function void note_buttons(logic left, logic right, logic clr);
    display_item_t d;
    logic          both;
    logic          wr;
    logic          dash;
    logic [16:0]   tenths;
    both = left & right;
    wr   = 1'b0;
    case (mode_q)
      tbsc_pkg::MODE_CLEAR: begin
        if (clr) begin
          phase_q = sat_inc(phase_q);
          if (phase_q >= cfg.clear_hold_ms) begin
            best_q   = tbsc_pkg::NO_RECORD;
            wr       = 1'b1;
            dashes_q = 1'b1;
          end
        end else begin
          mode_q  = tbsc_pkg::MODE_IDLE;
          phase_q = '0;
        end
      end
      tbsc_pkg::MODE_RELEASE: begin
        if (!left && !right) begin
          mode_q  = tbsc_pkg::MODE_COUNT;
          phase_q = '0;
        end
      end
      tbsc_pkg::MODE_COUNT: begin
        count_q  = (count_q < cfg.count_max) ? count_q + 17'd1 : '0;
        shown_q  = count_q;
        dashes_q = 1'b0;
        if (both) begin
          mode_q  = tbsc_pkg::MODE_SHOW;
          phase_q = '0;
          blink_q = '0;
        end
      end
      tbsc_pkg::MODE_SHOW: begin
        if ({15'd0, count_q} < best_q) begin
          best_q     = {15'd0, count_q};
          wr         = 1'b1;
          rec_flag_q = 1'b1;
        end
        phase_q = sat_inc(phase_q);
        blink_q = sat_inc(blink_q);
        if (phase_q >= cfg.show_ms) begin
          mode_q     = tbsc_pkg::MODE_IDLE;
          dashes_q   = 1'b1;
          phase_q    = '0;
          rec_flag_q = 1'b0;
          blank_q    = 1'b0;
        end else if (rec_flag_q && blink_q >= cfg.blink_ms) begin
          blink_q = '0;
          if (blank_q) begin
            shown_q  = count_q;
            dashes_q = 1'b0;
          end
          blank_q = !blank_q;
        end
      end
      default: begin
        // start buttons take priority over clear here
        mode_q = tbsc_pkg::MODE_IDLE;
        if (both) begin
          if (phase_q >= cfg.debounce_ms) begin
            count_q  = '0;
            shown_q  = '0;
            dashes_q = 1'b0;
            mode_q   = tbsc_pkg::MODE_RELEASE;
            phase_q  = '0;
          end else begin
            phase_q = sat_inc(phase_q);
          end
        end else begin
          phase_q = '0;
          if (clr) mode_q = tbsc_pkg::MODE_CLEAR;
        end
      end
    endcase

    dash   = dashes_q || (shown_q > tbsc_pkg::SHOW_LIMIT);
    tenths = shown_q / 17'd10;
    d.mode = mode_q;
    if (dash) begin
      d.display_value  = '0;
      d.point_position = 2'd3;
    end else if (shown_q <= tbsc_pkg::SMALL_LIMIT) begin
      d.display_value  = shown_q[13:0];
      d.point_position = 2'd3;
    end else begin
      d.display_value  = tenths[13:0];
      d.point_position = 2'd2;
    end
    d.show_dashes   = dash;
    d.display_blank = blank_q;
    d.elapsed_count = count_q;
    d.best_record   = best_q;
    d.new_record    = rec_flag_q;
    d.record_write  = wr;
    d.record_crc    = crc_of_best(best_q);
    expected_displays.push_back(d);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 200)
      $display("%0t result %0d: %s got %0h want %0h", $time, results_seen, what, got, want);
  endtask

  task check_display(display_item_t got);
    display_item_t want;
    results_seen++;
    if (expected_displays.size() == 0) begin
      report_mismatch("result item with none expected, mode", 32'(got.mode), '0);
    end else begin
      want = expected_displays.pop_front();
      if (got.mode !== want.mode)
        report_mismatch("mode", 32'(got.mode), 32'(want.mode));
      if (got.display_value !== want.display_value)
        report_mismatch("display_value", 32'(got.display_value), 32'(want.display_value));
      if (got.point_position !== want.point_position)
        report_mismatch("point_position", 32'(got.point_position), 32'(want.point_position));
      if (got.show_dashes !== want.show_dashes)
        report_mismatch("show_dashes", 32'(got.show_dashes), 32'(want.show_dashes));
      if (got.display_blank !== want.display_blank)
        report_mismatch("display_blank", 32'(got.display_blank), 32'(want.display_blank));
      if (got.elapsed_count !== want.elapsed_count)
        report_mismatch("elapsed_count", 32'(got.elapsed_count), 32'(want.elapsed_count));
      if (got.best_record !== want.best_record)
        report_mismatch("best_record", got.best_record, want.best_record);
      if (got.new_record !== want.new_record)
        report_mismatch("new_record", 32'(got.new_record), 32'(want.new_record));
      if (got.record_write !== want.record_write)
        report_mismatch("record_write", 32'(got.record_write), 32'(want.record_write));
      if (got.record_crc !== want.record_crc)
        report_mismatch("record_crc", got.record_crc, want.record_crc);
    end
  endtask
endclass

module two_button_stopwatch_controller_unit_tb;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned SPAN_CAP     = 150;

  logic        clk_i                 = 1'b0;
  logic        rst_ni                = 1'b0;
  logic        cfg_valid_i           = 1'b0;
  logic [2:0]  cfg_index_i           = tbsc_pkg::CFG_DEBOUNCE;
  logic [16:0] cfg_data_i            = '0;
  logic        in_valid_i            = 1'b0;
  logic        left_start_pressed_i  = 1'b0;
  logic        right_start_pressed_i = 1'b0;
  logic        clear_pressed_i       = 1'b0;
  logic        out_ready_i           = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  mode_o;
  logic [13:0] display_value_o;
  logic [1:0]  point_position_o;
  logic        show_dashes_o;
  logic        display_blank_o;
  logic [16:0] elapsed_count_o;
  logic [31:0] best_record_o;
  logic        new_record_o;
  logic        record_write_o;
  logic [31:0] record_crc_o;

  stopwatch_tracker tracker;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  bit               stall_request = 1'b0;
  int unsigned      stall_left    = 0;
  int unsigned      items_sent    = 0;
  int unsigned      cycles        = 0;

  two_button_stopwatch_controller_unit i_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_display({mode_o, display_value_o, point_position_o, show_dashes_o,
                             display_blank_o, elapsed_count_o, best_record_o,
                             new_record_o, record_write_o, record_crc_o});
  end

  // result side: random back-pressure plus the occasional long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left    = STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic coin(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned cap(input int unsigned v);
    return (v > SPAN_CAP) ? SPAN_CAP : v;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic left, input logic right, input logic clr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i            <= 1'b1;
    left_start_pressed_i  <= left;
    right_start_pressed_i <= right;
    clear_pressed_i       <= clr;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_buttons(left, right, clr);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic press(input logic left, input logic right, input logic clr,
                       input int unsigned n);
    repeat (n) send_item(left, right, clr);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic request_stall();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    stall_request = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] deb, clr_hold, show, blink,
                            input logic [16:0] cmax);
    drain();
    write_reg(tbsc_pkg::CFG_DEBOUNCE, {1'b0, deb});
    write_reg(tbsc_pkg::CFG_CLEAR_HOLD, {1'b0, clr_hold});
    write_reg(tbsc_pkg::CFG_SHOW, {1'b0, show});
    write_reg(tbsc_pkg::CFG_BLINK, {1'b0, blink});
    write_reg(tbsc_pkg::CFG_COUNT_MAX, cmax);
    cfg_valid_i <= 1'b0;
  endtask

  // steer the predicted mode back to idle, giving up on very long show times
  task automatic settle_idle();
    int unsigned guard;
    guard = 0;
    while (tracker.mode_q != tbsc_pkg::MODE_IDLE && guard < SPAN_CAP) begin
      send_item(tracker.mode_q == tbsc_pkg::MODE_COUNT,
                tracker.mode_q == tbsc_pkg::MODE_COUNT, 1'b0);
      guard++;
    end
  endtask

  task automatic run_sessions(input int unsigned n_items);
    int unsigned start;
    int unsigned hold;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        // arm, release, count, stop, show
        if (coin(70)) settle_idle();
        hold = cap(tracker.cfg.debounce_ms + 1 + $urandom_range(2));
        if (coin(10)) hold = $urandom_range(1, hold);
        repeat (hold) send_item(1'b1, 1'b1, coin(20));
        repeat ($urandom_range(3)) begin
          pick = $urandom_range(1);
          send_item(pick == 0, pick == 1, coin(20));
        end
        send_item(1'b0, 1'b0, coin(20));
        repeat ($urandom_range(cap(2 * tracker.cfg.count_max + 2))) begin
          pick = $urandom_range(2);
          send_item(pick == 1, pick == 2, coin(20));
        end
        repeat ($urandom_range(1, 3)) send_item(1'b1, 1'b1, coin(20));
        repeat (cap(tracker.cfg.show_ms + $urandom_range(3)))
          send_item(coin(12), coin(12), coin(12));
      end else if (pick < 8) begin
        // clear hold with at most one start button down
        hold = cap(tracker.cfg.clear_hold_ms + 2 + $urandom_range(3));
        if (coin(15)) hold = $urandom_range(1, hold);
        repeat (hold) send_item(coin(50), 1'b0, 1'b1);
        send_item(1'b0, 1'b0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 6)) send_item(coin(50), coin(50), coin(50));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 6;
    recv_idle_pct = 47;
    set_config(16'd2, 16'd3, 16'd6, 16'd2, 17'd40);
    // clear held past the hold time, then release
    press(1'b0, 1'b0, 1'b0, 1);
    press(1'b0, 1'b0, 1'b1, 5);
    press(1'b0, 1'b0, 1'b0, 1);
    // start and clear together in idle: start wins
    press(1'b1, 1'b1, 1'b1, 3);
    press(1'b1, 1'b0, 1'b0, 1);
    press(1'b0, 1'b0, 1'b0, 1);
    press(1'b0, 1'b1, 1'b0, 1);
    press(1'b1, 1'b0, 1'b1, 1);
    press(1'b0, 1'b0, 1'b1, 1);
    press(1'b1, 1'b0, 1'b0, 1);
    press(1'b0, 1'b0, 1'b0, 1);
    press(1'b1, 1'b1, 1'b0, 1);
    // first record, blinking, back to idle
    press(1'b0, 1'b0, 1'b0, 7);

    set_config(16'd0, 16'd0, 16'd1, 16'd1, 17'd1);
    run_sessions(200);

    send_idle_pct = 47;
    recv_idle_pct = 6;
    set_config(16'd3, 16'd5, 16'd12, 16'd3, 17'd200);
    run_sessions(150);
    drain();
    request_stall();
    run_sessions(150);

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
    run_sessions(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(16'd1, 16'd2, 16'd0, 16'd0, 17'd0);
    run_sessions(100);
    request_stall();
    run_sessions(100);

    // a longer count, then the maximum lowered under it: wraps on the next item
    set_config(16'd1, 16'd4, 16'd10, 16'd2, 17'h1FFFF);
    settle_idle();
    press(1'b1, 1'b1, 1'b0, 2);
    press(1'b0, 1'b0, 1'b0, 150);
    set_config(16'd1, 16'd4, 16'd10, 16'd2, 17'd100);
    press(1'b0, 1'b0, 1'b0, 150);
    press(1'b1, 1'b1, 1'b0, 1);
    run_sessions(100);

    set_config(16'd4, 16'd6, 16'd20, 16'd4, 17'd99999);
    run_sessions(100);

    drain();
    repeat (10) @(negedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
